// ===== rtl/lpht_pkg.sv =====
// Shared widths, codes and types of the linear probing hash table.
`default_nettype none

package lpht_pkg;

  localparam int KEY_W  = 31;  // record key
  localparam int CFG_W  = 9;   // slot counts, item counts, config registers
  localparam int TAG_W  = 2;   // slot tag
  localparam int ST_W   = 3;   // result status
  localparam int FN_W   = 2;   // operation code

  // Remainder unit: dividend padded to DIV_W, RADIX_BITS quotient bits per cycle.
  localparam int DIV_W      = 32;
  localparam int RADIX_BITS = 4;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CFG_W-1:0] cfg_t;
  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [ST_W-1:0]  status_t;
  typedef logic [FN_W-1:0]  func_t;

  localparam func_t FN_INSERT = 2'd0;
  localparam func_t FN_DELETE = 2'd1;
  localparam func_t FN_SEARCH = 2'd2;

  localparam tag_t TAG_EMPTY = 2'd0;
  localparam tag_t TAG_LIVE  = 2'd1;
  localparam tag_t TAG_GONE  = 2'd2;

  localparam status_t ST_INSERTED = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_REMOVED  = 3'd2;
  localparam status_t ST_MISSING  = 3'd3;
  localparam status_t ST_FOUND    = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/lpht_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/lpht_mod.sv =====
// Multi-cycle remainder unit: key modulo the slot count, four bits a cycle.
`default_nettype none

module lpht_mod (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire lpht_pkg::key_t dividend,
  input  wire lpht_pkg::cfg_t divisor,
  output logic               done,
  output lpht_pkg::cfg_t     rem
);
  import lpht_pkg::*;

  localparam int STEPS  = DIV_W / RADIX_BITS;
  localparam int STEP_W = $clog2(STEPS);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DIV_W-1:0]  dv_r, dv_nxt;
  cfg_t              dsr_r;
  cfg_t              rem_r, rem_nxt;
  logic [CFG_W:0]    trial;

  // Restoring remainder: the partial remainder stays below the divisor, so
  // one compare and subtract settles each bit.
  always_comb begin
    rem_nxt = rem_r;
    dv_nxt  = dv_r;
    trial   = '0;
    for (int i = 0; i < RADIX_BITS; i++) begin
      trial = {rem_nxt, dv_nxt[DIV_W-1]};
      if (trial >= {1'b0, dsr_r}) begin
        trial = trial - {1'b0, dsr_r};
      end
      rem_nxt = trial[CFG_W-1:0];
      dv_nxt  = {dv_nxt[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv_r  <= {1'b0, dividend};
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dv_r  <= dv_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== rtl/linear_probe_hash_table.sv =====
// Top level of the linear probing hash table: control, config port, slot memory.
`default_nettype none

// Open-addressing hash table with linear probing. A command word is taken on
// a clock edge with start high and busy low; each command gives exactly one
// result word, shown for a single cycle with out_strobe high, which the
// receiver must take then, since it cannot hold results off. After reset the
// block sweeps the slot memory to empty, one slot a cycle, with busy high;
// config writes are taken during the sweep. An insert refused by the item
// limit and an unused operation code answer in the cycle after acceptance,
// and the block is free again at once. Any other command first forms key
// modulo the slot count (a registered go flag kicks the remainder unit, which
// runs until done, and its result is taken as the home slot), then reads the
// home slot and checks one slot per probe, since the single slot memory
// delivers one entry a cycle. The result strobe follows the last probe, and
// busy drops at the same edge. Each slot word holds tag, key and payload
// together, so a delete rewrites the word it just read.
// Configure only while idle: table_slots at byte address 0, max_items at 4.
module linear_probe_hash_table #(
  parameter int TABLE_DEPTH  = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // command channel
  input  wire logic                    start,
  output logic                         busy,
  input  wire lpht_pkg::func_t         in_func,
  input  wire lpht_pkg::key_t          in_key,
  input  wire logic [PAYLOAD_BITS-1:0] in_payload,
  // result channel
  output logic                         out_strobe,
  output lpht_pkg::status_t            out_status,
  output logic [PAYLOAD_BITS-1:0]      out_found_payload,
  output lpht_pkg::cfg_t               out_item_count,
  // configuration port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import lpht_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W = TAG_W + KEY_W + PAYLOAD_BITS;

  // Largest usable slot count in this instance: the depth, saturated to the register's range.
  localparam cfg_t DEPTH_CAP = (TABLE_DEPTH > 511) ? '1 : CFG_W'(TABLE_DEPTH);

  // Register select: bit 2 of the byte address.
  localparam logic REG_SLOTS = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  cfg_t              live_cnt_r, live_cnt_nxt;
  cfg_t              table_slots_r, max_items_r;

  // Latched command.
  func_t             func_r, func_nxt;
  key_t              key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;

  // Probe position and probe count.
  cfg_t              pos_r, pos_nxt;
  cfg_t              n_r, n_nxt;

  // Result word.
  logic              out_strobe_r, out_strobe_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [PAYLOAD_BITS-1:0] out_pay_r, out_pay_nxt;
  cfg_t              out_cnt_r, out_cnt_nxt;

  // Slot memory.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  tag_t              rd_tag;
  key_t              rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  // Remainder unit.
  logic              mod_start, mod_done;
  cfg_t              mod_rem;

  // Derived configuration and probe helpers.
  cfg_t              slots, limit;
  logic              full;
  logic [CFG_W:0]    pos_p1;
  cfg_t              pos_inc;
  logic              last_probe;
  logic              finish;
  status_t           fin_status;
  logic [PAYLOAD_BITS-1:0] fin_pay;
  logic              cfg_wr;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_slots_r <= 9'd256;
      max_items_r   <= 9'd256;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SLOTS: table_slots_r <= pwdata[CFG_W-1:0];
        REG_LIMIT: max_items_r   <= pwdata[CFG_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SLOTS: prdata = 32'(table_slots_r);
      REG_LIMIT: prdata = 32'(max_items_r);
      default:   prdata = '0;
    endcase
  end

  // Slot count clamped to [1, depth]; item limit saturated to the slot count.
  always_comb begin
    if (table_slots_r == '0) begin
      slots = CFG_W'(1);
    end else if (table_slots_r > DEPTH_CAP) begin
      slots = DEPTH_CAP;
    end else begin
      slots = table_slots_r;
    end
    limit = (max_items_r < slots) ? max_items_r : slots;
    full  = (live_cnt_r >= limit);
  end

  // Next slot, wrapping at the slot count; last probe when n reaches slots-1.
  assign pos_p1     = {1'b0, pos_r} + (CFG_W+1)'(1);
  assign pos_inc    = (pos_p1 == {1'b0, slots}) ? '0 : pos_p1[CFG_W-1:0];
  assign last_probe = ({1'b0, n_r} + (CFG_W+1)'(1)) == {1'b0, slots};

  // ---------------------------------------------------------------------------
  // Slot memory: {tag, key, payload} per slot
  // ---------------------------------------------------------------------------
  assign rd_tag = ram_rdata[ENTRY_W-1 -: TAG_W];
  assign rd_key = ram_rdata[PAYLOAD_BITS +: KEY_W];
  assign rd_pay = ram_rdata[PAYLOAD_BITS-1:0];

  lpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lpht_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (key_r),
    .divisor  (slots),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    live_cnt_nxt   = live_cnt_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    pos_nxt        = pos_r;
    n_nxt          = n_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_pay_nxt    = out_pay_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = IDX_W'(pos_r);
    ram_wdata      = '0;
    ram_raddr      = IDX_W'(pos_r);
    finish         = 1'b0;
    fin_status     = ST_MISSING;
    fin_pay        = '0;

    unique case (state_r)
      S_CLEAR: begin
        // Sweep every slot to empty after reset.
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = {TAG_EMPTY, {(KEY_W+PAYLOAD_BITS){1'b0}}};
        if (clr_r == IDX_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + IDX_W'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          func_nxt = in_func;
          key_nxt  = in_key;
          pay_nxt  = in_payload;
          case (in_func) inside
            FN_INSERT: begin
              if (full) begin
                finish     = 1'b1;
                fin_status = ST_FULL;
              end else begin
                state_nxt = S_HASH;
              end
            end
            FN_DELETE, FN_SEARCH: begin
              state_nxt = S_HASH;
            end
            default: begin
              finish     = 1'b1;
              fin_status = ST_MISSING;
            end
          endcase
        end
      end

      S_HASH: begin
        // Key is latched; the unit starts the cycle after acceptance.
        if (mod_done) begin
          pos_nxt   = mod_rem;
          n_nxt     = '0;
          state_nxt = S_PROBE;
        end
      end

      S_PROBE: begin
        ram_raddr = IDX_W'(pos_r);
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        // Fetch the next slot ahead; dropped if this slot ends the probe.
        ram_raddr = IDX_W'(pos_inc);
        case (func_r)
          FN_INSERT: begin
            if (rd_tag != TAG_LIVE) begin
              ram_we       = 1'b1;
              ram_wdata    = {TAG_LIVE, key_r, pay_r};
              live_cnt_nxt = live_cnt_r + CFG_W'(1);
              finish       = 1'b1;
              fin_status   = ST_INSERTED;
            end else if (last_probe) begin
              finish     = 1'b1;
              fin_status = ST_FULL;
            end
          end
          FN_DELETE: begin
            if (rd_tag == TAG_EMPTY) begin
              finish = 1'b1;
            end else if (rd_tag == TAG_LIVE && rd_key == key_r) begin
              ram_we    = 1'b1;
              ram_wdata = {TAG_GONE, rd_key, rd_pay};
              if (live_cnt_r != '0) begin
                live_cnt_nxt = live_cnt_r - CFG_W'(1);
              end
              finish     = 1'b1;
              fin_status = ST_REMOVED;
            end else if (last_probe) begin
              finish = 1'b1;
            end
          end
          FN_SEARCH: begin
            if (rd_tag == TAG_EMPTY) begin
              finish = 1'b1;
            end else if (rd_tag == TAG_LIVE && rd_key == key_r) begin
              finish     = 1'b1;
              fin_status = ST_FOUND;
              fin_pay    = rd_pay;
            end else if (last_probe) begin
              finish = 1'b1;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        if (finish) begin
          state_nxt = S_IDLE;
        end else begin
          pos_nxt = pos_inc;
          n_nxt   = n_r + CFG_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      out_strobe_nxt = 1'b1;
      out_status_nxt = fin_status;
      out_pay_nxt    = fin_pay;
      out_cnt_nxt    = live_cnt_nxt;
    end
  end

  // Start the remainder unit on the cycle after the key is latched.
  logic hash_go_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      live_cnt_r   <= '0;
      out_strobe_r <= 1'b0;
      hash_go_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      live_cnt_r   <= live_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      hash_go_r    <= (state_r == S_IDLE) && (state_nxt == S_HASH);
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    pos_r        <= pos_nxt;
    n_r          <= n_nxt;
    out_status_r <= out_status_nxt;
    out_pay_r    <= out_pay_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_found_payload = out_pay_r;
  assign out_item_count    = out_cnt_r;

  // The unit is kicked from the registered go flag so it sees the latched key.
  assign mod_start = hash_go_r;

`ifndef SYNTHESIS
  // Memory is written only by the reset sweep or at the end of a probe.
  a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_CHECK))
    else $error("slot memory written outside sweep or probe check");

  // The live count moves only together with a delivered result.
  a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (live_cnt_r != $past(live_cnt_r)) |-> out_strobe_r)
    else $error("live count changed without a result word");

  // Probe position and probe count stay inside the slots in use.
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (pos_r < slots && n_r < slots))
    else $error("probe outside the slots in use");

  // The remainder unit reports only while a command waits for its home slot.
  a_hash_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_HASH))
    else $error("remainder done outside hash state");
`endif

endmodule

`default_nettype wire
